>>> sv/jte_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jte_pkg
// shared sizes, codes and command/status bundles of the job table engine
// ----------------------------------------------------------------------------
package jte_pkg;

	localparam int unsigned TABLE_ENTRIES = 16;
	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam int unsigned PID_W = 22;
	localparam int unsigned JID_W = 5;
	localparam int unsigned RST_W = 2;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned STAT_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND_PID = 3'd2;
	localparam logic [CMD_W-1:0] CMD_FIND_JID = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND_FG  = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_PID   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd3;

	localparam logic [RST_W-1:0] RUN_FG = 2'd1;

	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [JID_W-1:0] jid;
		logic [RST_W-1:0] run;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT,
		S_MAX,
		S_MAX_DRAIN,
		S_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic             load_in;
		logic             start;
		logic             rd_en;
		logic             rd_max;
		logic [IDX_W-1:0] rd_addr;
		logic             commit;
		logic             load_out;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;
		logic cmd_del;
		logic found;
		logic out_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

>>> sv/jte_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jte_ctrl
// sequencer: decode, table scan, commit, job id maximum scan, result hand-off
// ----------------------------------------------------------------------------
module jte_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire jte_pkg::dp_stat_t  stat,
	output jte_pkg::ctrl_cmd_t      cmd
);

	jte_pkg::state_t state_q, state_d;
	logic [jte_pkg::IDX_W-1:0] cnt_q;
	logic last;

	assign last = (cnt_q == jte_pkg::IDX_W'(jte_pkg::TABLE_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jte_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == jte_pkg::S_SCAN || state_q == jte_pkg::S_MAX) && !last)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			jte_pkg::S_IDLE:      if (in_valid) state_d = jte_pkg::S_DECODE;
			jte_pkg::S_DECODE:    state_d = stat.skip ? jte_pkg::S_FINISH : jte_pkg::S_SCAN;
			jte_pkg::S_SCAN:      if (last) state_d = jte_pkg::S_DRAIN;
			jte_pkg::S_DRAIN:     state_d = jte_pkg::S_COMMIT;
			jte_pkg::S_COMMIT:    state_d = (stat.cmd_del && stat.found) ?
			                                jte_pkg::S_MAX : jte_pkg::S_FINISH;
			jte_pkg::S_MAX:       if (last) state_d = jte_pkg::S_MAX_DRAIN;
			jte_pkg::S_MAX_DRAIN: state_d = jte_pkg::S_FINISH;
			jte_pkg::S_FINISH:    if (!stat.out_busy) state_d = jte_pkg::S_IDLE;
			default:              state_d = jte_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd         = '0;
		cmd.rd_addr = cnt_q;
		in_ready    = 1'b0;
		unique case (state_q)
			jte_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			jte_pkg::S_DECODE: cmd.start = 1'b1;
			jte_pkg::S_SCAN:   cmd.rd_en = 1'b1;
			jte_pkg::S_COMMIT: cmd.commit = 1'b1;
			jte_pkg::S_MAX: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_max = 1'b1;
			end
			jte_pkg::S_FINISH: cmd.load_out = !stat.out_busy;
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/jte_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jte_dpath
// entry memory with valid bits, match/maximum logic, job id counter, result register
// ----------------------------------------------------------------------------
module jte_dpath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire jte_pkg::ctrl_cmd_t          cmd,
	output jte_pkg::dp_stat_t                stat,
	input  wire logic [31:0]                 in_data,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [31:0]                      out_data
);

	jte_pkg::entry_t mem [jte_pkg::TABLE_ENTRIES];
	logic [jte_pkg::TABLE_ENTRIES-1:0] valid_q;

	// item registers
	logic [jte_pkg::CMD_W-1:0] icmd_q;
	logic [jte_pkg::PID_W-1:0] ipid_q;
	logic [jte_pkg::JID_W-1:0] ijid_q;
	logic [jte_pkg::RST_W-1:0] irun_q;

	// read stage
	logic                      rd_vld_s1, rd_max_s1, ent_valid_s1;
	logic [jte_pkg::IDX_W-1:0] idx_s1;
	jte_pkg::entry_t           ent_s1;
	jte_pkg::entry_t           eff;

	logic                      found_q;
	logic [jte_pkg::IDX_W-1:0] slot_q;
	jte_pkg::entry_t           hit_q;
	logic [jte_pkg::JID_W-1:0] max_q;
	logic [jte_pkg::JID_W-1:0] next_jid_q;

	logic                       out_valid_q;
	logic [jte_pkg::STAT_W-1:0] ostat_q;
	jte_pkg::entry_t            oent_q;

	logic pid_zero, bad_pid, unused_cmd, match;
	logic [jte_pkg::JID_W:0] add_n, del_n;
	logic [jte_pkg::JID_W-1:0] add_next, del_next;
	logic [jte_pkg::STAT_W-1:0] res_stat;

	assign pid_zero   = (ipid_q == '0);
	assign bad_pid    = pid_zero && (icmd_q == jte_pkg::CMD_ADD ||
	                    icmd_q == jte_pkg::CMD_DELETE || icmd_q == jte_pkg::CMD_FIND_PID);
	assign unused_cmd = (icmd_q > jte_pkg::CMD_FIND_FG);

	assign stat.skip     = bad_pid || unused_cmd;
	assign stat.cmd_del  = (icmd_q == jte_pkg::CMD_DELETE);
	assign stat.found    = found_q;
	assign stat.out_busy = out_valid_q && !out_ready;

	// a free entry reads as all zero
	assign eff = ent_valid_s1 ? ent_s1 : '0;

	always_comb begin
		case (icmd_q) inside
			jte_pkg::CMD_ADD:      match = !ent_valid_s1;
			jte_pkg::CMD_DELETE,
			jte_pkg::CMD_FIND_PID: match = ent_valid_s1 && (ent_s1.pid == ipid_q);
			jte_pkg::CMD_FIND_JID: match = (ijid_q != '0) && (eff.jid == ijid_q);
			jte_pkg::CMD_FIND_FG:  match = (eff.run == jte_pkg::RUN_FG);
			default:               match = 1'b0;
		endcase
	end

	// counter after add: wrap past table size, never zero
	always_comb begin
		add_n = {1'b0, next_jid_q} + 1'b1;
		if (32'(add_n) > jte_pkg::TABLE_ENTRIES)
			add_n = (jte_pkg::JID_W+1)'(1);
		add_next = (add_n[jte_pkg::JID_W-1:0] == '0) ?
		           jte_pkg::JID_W'(1) : add_n[jte_pkg::JID_W-1:0];
		del_n    = {1'b0, max_q} + 1'b1;
		del_next = (del_n[jte_pkg::JID_W-1:0] == '0) ?
		           jte_pkg::JID_W'(1) : del_n[jte_pkg::JID_W-1:0];
	end

	always_comb begin
		if (bad_pid)
			res_stat = jte_pkg::STAT_BAD_PID;
		else if (unused_cmd)
			res_stat = jte_pkg::STAT_NOT_FOUND;
		else if (found_q)
			res_stat = jte_pkg::STAT_OK;
		else if (icmd_q == jte_pkg::CMD_ADD)
			res_stat = jte_pkg::STAT_FULL;
		else
			res_stat = jte_pkg::STAT_NOT_FOUND;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rd_max_s1   <= 1'b0;
			found_q     <= 1'b0;
			next_jid_q  <= jte_pkg::JID_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			rd_max_s1 <= cmd.rd_max;
			if (cmd.start)
				found_q <= 1'b0;
			else if (rd_vld_s1 && !rd_max_s1 && match)
				found_q <= 1'b1;
			if (cmd.commit && found_q) begin
				if (icmd_q == jte_pkg::CMD_ADD) begin
					valid_q[slot_q] <= 1'b1;
					next_jid_q      <= add_next;
				end else if (icmd_q == jte_pkg::CMD_DELETE) begin
					valid_q[slot_q] <= 1'b0;
				end
			end
			if (cmd.load_out && found_q && !stat.skip && icmd_q == jte_pkg::CMD_DELETE)
				next_jid_q <= del_next;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			icmd_q <= in_data[2:0];
			ipid_q <= in_data[24:3];
			ijid_q <= in_data[29:25];
			irun_q <= in_data[31:30];
		end
		ent_s1       <= mem[cmd.rd_addr];
		ent_valid_s1 <= valid_q[cmd.rd_addr];
		idx_s1       <= cmd.rd_addr;
		if (rd_vld_s1 && !rd_max_s1 && match && !found_q) begin
			slot_q <= idx_s1;
			hit_q  <= eff;
		end
		if (cmd.commit)
			max_q <= '0;
		else if (rd_vld_s1 && rd_max_s1 && eff.jid > max_q)
			max_q <= eff.jid;
		if (cmd.commit && found_q && icmd_q == jte_pkg::CMD_ADD) begin
			mem[slot_q] <= '{pid: ipid_q, jid: next_jid_q, run: irun_q};
			hit_q       <= '{pid: ipid_q, jid: next_jid_q, run: irun_q};
		end
		if (cmd.load_out) begin
			ostat_q <= res_stat;
			oent_q  <= (res_stat == jte_pkg::STAT_OK) ? hit_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {1'b0, oent_q.run, oent_q.jid, oent_q.pid, ostat_q};

endmodule
`default_nettype wire

>>> sv/job_table_engine_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// job_table_engine_unit
// job table: add, delete and lookups over a fixed table of job entries
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   32     command, proc_id, job_id, run_state
//  m_axis    out  32     status, found_proc, found_job, found_state
//
//  scans: one command makes one sequential scan of the entry memory, one entry
//  a cycle; a delete that hits adds a second scan for the largest job id; a
//  zero pid on add, delete or find by pid, or an unused code, skips the scans
//  reset: arst_n clears the valid bits and sets the job id counter to one,
//  no clearing pass is needed
//  stalls: a new command transfer is taken while the previous result waits
//  on m_axis; the new result is held until that transfer has completed
// ----------------------------------------------------------------------------
module job_table_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [2:0] command, [24:3] proc_id, [29:25] job_id, [31:30] run_state
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status, [23:2] found_proc, [28:24] found_job, [30:29] found_state,
	// [31] zero
	output logic [31:0]      m_tdata
);

	// command and status between sequencer and datapath
	jte_pkg::ctrl_cmd_t cmd;
	jte_pkg::dp_stat_t  stat;

	// sequencer: accepts one command transfer, then steps the scans
	jte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: table memory, match logic and result register
	jte_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
`default_nettype wire

>>> verif/job_table_engine_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// job_table_engine_unit_tb
// self-checking bench for the job table engine stream unit
// ----------------------------------------------------------------------------
// a behavioral copy of the job table runs beside the block: every command
// transfer accepted on s_* updates it and queues the expected response, and
// every response transfer on m_* is compared field by field against the
// oldest queued one. directed tests cover rejects, a full table and the job
// id counter reaching its top value; a long random run then mixes adds,
// deletes and lookups with a drifting add/delete balance so the table swings
// between empty and full. both sides idle at random, and one test parks the
// response side for a long stretch so the block backs up onto its input.
// ----------------------------------------------------------------------------
module job_table_engine_unit_tb;
	import jte_pkg::*;

	// one command transfer on s_tdata, packed from bit 0 up:
	// op, pid, jid, run
	typedef struct packed {
		logic [RST_W-1:0] run;
		logic [JID_W-1:0] jid;
		logic [PID_W-1:0] pid;
		logic [CMD_W-1:0] op;
	} job_cmd_t;

	// one response transfer on m_tdata[30:0], packed from bit 0 up:
	// status, pid, jid, run
	typedef struct packed {
		logic [RST_W-1:0]  run;
		logic [JID_W-1:0]  jid;
		logic [PID_W-1:0]  pid;
		logic [STAT_W-1:0] status;
	} job_result_t;

	// command codes the block answers with not found
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	localparam logic [PID_W-1:0] PID_FREE = '0;
	localparam logic [PID_W-1:0] PID_MAX  = '1;
	localparam int unsigned      JID_TOP  = TABLE_ENTRIES + 1;
	localparam logic [RST_W-1:0] RUN_MAX  = '1;

	localparam int LONG_HOLD     = 400;
	// a delete that hits runs two scans of the table
	localparam int SETTLE_CYCLES = 2 * TABLE_ENTRIES + 20;
	localparam int RANDOM_ITEMS  = 1800;
	// timeout covers the slowest run of roughly 1900 items several times over
	localparam int TIMEOUT_TIME  = 12_000_000;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	// shadow of the job table and its counter
	entry_t           job_tbl [TABLE_ENTRIES];
	logic [JID_W-1:0] next_jid;

	job_result_t pending_results [$];
	int          errors = 0;

	// sender pacing
	int burst_left = 0;
	bit sender_no_gaps = 1'b0;
	// share of adds among adds and deletes in the random run, in percent
	int add_share = 50;

	// long response hold-off, requested by a test and served by the receiver
	int hold_requests = 0;
	int holds_served  = 0;

	job_table_engine_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_TIME);
		$display("job_table_engine_unit test failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// job table shadow
	// ------------------------------------------------------------------------

	// job id counter is 5 bits wide; zero after masking turns into one
	function automatic logic [JID_W-1:0] wrap_jid(input int v);
		logic [JID_W-1:0] m;
		m = v[JID_W-1:0];
		return (m == '0) ? JID_W'(1) : m;
	endfunction

	// applies one command to the shadow table and returns its response
	function automatic job_result_t apply_job_cmd(input job_cmd_t c);
		job_result_t r;
		int          slot;
		int          top;
		int          n;
		bit          hit;
		r = '0;
		slot = -1;
		// pid zero is refused before any scan
		if ((c.op == CMD_ADD || c.op == CMD_DELETE || c.op == CMD_FIND_PID) &&
		    c.pid == PID_FREE) begin
			r.status = STAT_BAD_PID;
			return r;
		end
		// lowest matching slot wins
		for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
			case (c.op)
				CMD_ADD:                  hit = (job_tbl[i].pid == PID_FREE);
				CMD_DELETE, CMD_FIND_PID: hit = (job_tbl[i].pid == c.pid);
				// free slots hold jid zero, so a zero key never matches
				CMD_FIND_JID:             hit = (c.jid != '0) && (job_tbl[i].jid == c.jid);
				CMD_FIND_FG:              hit = (job_tbl[i].run == RUN_FG);
				default:                  hit = 1'b0;
			endcase
			if (hit)
				slot = i;
		end
		if (slot < 0) begin
			r.status = (c.op == CMD_ADD) ? STAT_FULL : STAT_NOT_FOUND;
			return r;
		end
		if (c.op == CMD_ADD) begin
			job_tbl[slot] = '{pid: c.pid, jid: next_jid, run: c.run};
			n = int'(next_jid) + 1;
			next_jid = wrap_jid((n > TABLE_ENTRIES) ? 1 : n);
		end
		// delete reports the entry as it was before clearing
		r.status = STAT_OK;
		r.pid    = job_tbl[slot].pid;
		r.jid    = job_tbl[slot].jid;
		r.run    = job_tbl[slot].run;
		if (c.op == CMD_DELETE) begin
			job_tbl[slot] = '0;
			top = 0;
			foreach (job_tbl[k])
				if (int'(job_tbl[k].jid) > top)
					top = int'(job_tbl[k].jid);
			next_jid = wrap_jid(top + 1);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offers one command until it is taken, then maybe idles between bursts
	task automatic send_job_cmd(input job_cmd_t c);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(apply_job_cmd(c));
		if (!sender_no_gaps) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				                                  : $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 30);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic send_op(input logic [CMD_W-1:0] op, input logic [PID_W-1:0] pid,
	                       input logic [JID_W-1:0] jid, input logic [RST_W-1:0] run);
		send_job_cmd('{run: run, jid: jid, pid: pid, op: op});
	endtask

	// sender stands still until every queued response has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// live pid with the given odds, zero now and then, otherwise a fresh one
	function automatic logic [PID_W-1:0] pick_pid(input int live_pct, input int zero_pct);
		int live_slots [$];
		int r;
		foreach (job_tbl[i])
			if (job_tbl[i].pid != PID_FREE)
				live_slots.push_back(i);
		r = $urandom_range(0, 99);
		if (r < zero_pct)
			return PID_FREE;
		if (r < zero_pct + live_pct && live_slots.size() > 0)
			return job_tbl[live_slots[$urandom_range(0, live_slots.size() - 1)]].pid;
		case ($urandom_range(0, 3))
			// small ids so that fresh adds collide with live ones at times
			0:       return PID_W'($urandom_range(1, 40));
			1:       return PID_MAX - PID_W'($urandom_range(0, 3));
			default: return PID_W'($urandom_range(1, PID_MAX));
		endcase
	endfunction

	function automatic logic [JID_W-1:0] pick_jid();
		int live_slots [$];
		foreach (job_tbl[i])
			if (job_tbl[i].pid != PID_FREE)
				live_slots.push_back(i);
		if ($urandom_range(0, 99) < 60 && live_slots.size() > 0)
			return job_tbl[live_slots[$urandom_range(0, live_slots.size() - 1)]].jid;
		return JID_W'($urandom_range(0, JID_TOP));
	endfunction

	function automatic job_cmd_t random_job_cmd();
		job_cmd_t c;
		int       r;
		// fields the command does not use still carry random bits
		c.pid = PID_W'($urandom_range(0, PID_MAX));
		c.jid = JID_W'($urandom_range(0, JID_TOP));
		c.run = RST_W'($urandom_range(0, RUN_MAX));
		r = $urandom_range(0, 99);
		if (r < 4) begin
			c.op = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		end else if (r < 60) begin
			if ($urandom_range(0, 99) < add_share) begin
				c.op  = CMD_ADD;
				c.pid = pick_pid(10, 4);
			end else begin
				c.op  = CMD_DELETE;
				c.pid = pick_pid(75, 4);
			end
		end else if (r < 78) begin
			c.op  = CMD_FIND_PID;
			c.pid = pick_pid(60, 5);
		end else if (r < 90) begin
			c.op  = CMD_FIND_JID;
			c.jid = pick_jid();
		end else begin
			c.op = CMD_FIND_FG;
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// refused and empty-table cases
	task automatic test_rejects();
		send_op(CMD_FIND_FG, PID_MAX, JID_W'(TABLE_ENTRIES), RUN_FG);
		send_op(CMD_FIND_JID, PID_MAX, '0, RUN_MAX);
		send_op(CMD_ADD, PID_FREE, '1, RUN_FG);
		send_op(CMD_DELETE, PID_FREE, '1, RUN_MAX);
		send_op(CMD_FIND_PID, PID_FREE, '0, '0);
		send_op(CMD_DELETE, PID_W'(7), '0, '0);
		send_op(CMD_SPARE_FIRST, PID_MAX, JID_W'(JID_TOP), RUN_MAX);
		send_op(CMD_SPARE_LAST, PID_W'(1), '0, RUN_FG);
	endtask

	// fills every slot, then one more add that finds the table full
	task automatic test_fill_table();
		logic [PID_W-1:0] pid;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			case (k)
				0:       pid = PID_W'(1);
				1:       pid = PID_MAX;
				2:       pid = 22'h2AAAAA;
				3:       pid = 22'h155555;
				default: pid = PID_W'($urandom_range(2, PID_MAX - 1));
			endcase
			send_op(CMD_ADD, pid, JID_W'($urandom_range(0, JID_TOP)), RST_W'(k % 4));
		end
		send_op(CMD_ADD, PID_W'(12345), '0, RUN_FG);
	endtask

	// freeing slot 0 leaves job 16 as the largest, so the counter goes to
	// 17 and the next add wraps it back to one
	task automatic test_counter_wrap();
		send_op(CMD_DELETE, PID_W'(1), '0, '0);
		send_op(CMD_ADD, PID_MAX - PID_W'(1), '0, RUN_FG);
		send_op(CMD_FIND_JID, '0, JID_W'(JID_TOP), '0);
		send_op(CMD_FIND_FG, '0, '0, '0);
	endtask

	// response side parks while commands keep coming, block backs up
	task automatic test_backpressure();
		hold_requests++;
		sender_no_gaps = 1'b1;
		repeat (20) send_job_cmd(random_job_cmd());
		sender_no_gaps = 1'b0;
	endtask

	// random traffic with the add/delete balance drifting between phases
	task automatic test_random_traffic(input int n);
		int phase_left;
		phase_left = 0;
		for (int k = 0; k < n; k++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0:       add_share = 15;
					1:       add_share = 50;
					default: add_share = 85;
				endcase
				phase_left = $urandom_range(40, 120);
			end
			phase_left--;
			send_job_cmd(random_job_cmd());
		end
	endtask

	// ------------------------------------------------------------------------
	// response side
	// ------------------------------------------------------------------------

	// stall pattern: runs of always ready, coin flip, mostly stalled, mostly
	// ready, plus the long hold-off when a test asks for one
	always @(posedge clk) begin : rx_pace
		int rx_mode;
		int rx_left;
		int hold_left;
		if (hold_left == 0 && hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(8, 80);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 1) == 0);
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	task automatic check_field(input string name, input int unsigned want,
	                           input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	// every response transfer against the oldest expectation
	always @(posedge clk) begin : check_results
		job_result_t want;
		job_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[30:0];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual %h",
				         $time, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(got.status));
				check_field("found_proc", 32'(want.pid), 32'(got.pid));
				check_field("found_job", 32'(want.jid), 32'(got.jid));
				check_field("found_state", 32'(want.run), 32'(got.run));
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin : run_tests
		foreach (job_tbl[i])
			job_tbl[i] = '0;
		next_jid = JID_W'(1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_rejects();
		wait_drained();
		test_fill_table();
		wait_drained();
		test_counter_wrap();
		wait_drained();
		test_backpressure();
		wait_drained();
		test_random_traffic(RANDOM_ITEMS);
		wait_drained();

		// anything still coming out now has no expectation left
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("job_table_engine_unit test passed");
		else
			$display("job_table_engine_unit test failed");
		$finish;
	end

endmodule
`default_nettype wire
